// ===== rtl/eff_pkg.sv =====
package eff_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int TIME_BITS   = 48;
  localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int DUR_W       = 32;
  localparam int SRV_W       = 5;
  localparam int CNT_W       = 5;
  localparam int OUT_TIME_W  = 48;
  localparam int SUM_W       = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;

  localparam logic [CNT_W-1:0]     CNT_RESET = CNT_W'(16);
  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

  // Running best and second-best candidate handed down the cell row
  typedef struct packed {
    logic                 vld;
    logic                 best_vld;
    logic [TIME_BITS-1:0] best_t;
    logic [IDX_W-1:0]     best_idx;
    logic                 sec_vld;
    logic [TIME_BITS-1:0] sec_t;
    logic [IDX_W-1:0]     sec_idx;
  } eff_carry_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [TIME_BITS-1:0] val;
  } eff_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SWEEP,
    ST_SUM,
    ST_DONE
  } eff_state_t;

endpackage

// ===== rtl/eff_cell.sv =====
module eff_cell
  import eff_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             active,
  input  logic             clr,
  input  eff_wr_t          wr,
  input  eff_carry_t       carry_in,
  output eff_carry_t       carry_out
);

  logic [TIME_BITS-1:0] time_r;
  eff_carry_t           carry_r;
  eff_carry_t           carry_nxt;
  logic                 beats_best;
  logic                 beats_sec;

  assign beats_best = !carry_in.best_vld || (time_r < carry_in.best_t);
  assign beats_sec  = !carry_in.sec_vld || (time_r < carry_in.sec_t);

  // Strict compares keep the lower-numbered server on a tie
  always_comb begin
    carry_nxt = carry_in;
    if (active) begin
      if (beats_best) begin
        carry_nxt.sec_vld  = carry_in.best_vld;
        carry_nxt.sec_t    = carry_in.best_t;
        carry_nxt.sec_idx  = carry_in.best_idx;
        carry_nxt.best_vld = 1'b1;
        carry_nxt.best_t   = time_r;
        carry_nxt.best_idx = cell_idx;
      end else if (beats_sec) begin
        carry_nxt.sec_vld = 1'b1;
        carry_nxt.sec_t   = time_r;
        carry_nxt.sec_idx = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (clr) begin
      time_r <= '0;
    end else if (wr.en && (wr.idx == cell_idx)) begin
      time_r <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;

endmodule

// ===== rtl/earliest_free_server_dispatch.sv =====
// Earliest-free server dispatcher.
// Input: raise start with in_job_duration and in_first_of_batch; the item is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been computed.
// Config: cfg_we with cfg_wdata loads the server count; write it only while
// busy is low and no result is pending. A count of 0 acts as 1.
// Each server's busy-until time sits in one cell of a row of MAX_SERVERS
// cells. A candidate sweeps the row one cell per clock, keeping the earliest
// and second-earliest server. An item passes through launch, the row sweep,
// the saturating add, then the write-back and result select. The result
// appears on out_* with out_valid high for exactly one cycle; the receiver
// has no way to stall it. A new item may be accepted in that same output
// cycle.
// Reset clears every server time to zero and sets the count to 16.
module earliest_free_server_dispatch
  import eff_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DUR_W-1:0]      in_job_duration,
  input  logic                  in_first_of_batch,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  output logic [SRV_W-1:0]      out_assigned_server,
  output logic [SRV_W-1:0]      out_next_server,
  output logic [OUT_TIME_W-1:0] out_next_free_time
);

  eff_state_t            state_r;
  eff_state_t            state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [DUR_W-1:0]      dur_r;
  eff_carry_t            res_r;
  logic [TIME_BITS-1:0]  sum_r;
  logic                  out_valid_r;
  logic [SRV_W-1:0]      out_assigned_r;
  logic [SRV_W-1:0]      out_next_r;
  logic [OUT_TIME_W-1:0] out_time_r;

  logic                  accept;
  logic                  clr;
  logic                  launch;
  logic                  do_write;
  logic [MAX_SERVERS-1:0] active;
  eff_carry_t            chain [MAX_SERVERS+1];
  eff_wr_t               wr;
  logic [SUM_W-1:0]      sum_full;
  logic [TIME_BITS-1:0]  sum_sat;
  logic                  take_sec;

  assign accept = start && !busy;
  assign clr    = accept && in_first_of_batch;

  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      active[i] = (cnt_r == '0) ? (i == 0) : (i < int'(cnt_r));
    end
  end

  always_comb begin
    chain[0]      = '0;
    chain[0].vld  = launch;
  end

  assign wr.en  = do_write;
  assign wr.idx = res_r.best_idx;
  assign wr.val = sum_r;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    eff_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .active    (active[g]),
      .clr       (clr),
      .wr        (wr),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_SWEEP;
      ST_SWEEP:  if (chain[MAX_SERVERS].vld) state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy     = 1'b1;
    launch   = 1'b0;
    do_write = 1'b0;
    case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_LAUNCH: launch = 1'b1;
      ST_SWEEP:  ;
      ST_SUM:    ;
      ST_DONE:   do_write = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  // Saturating add of the job onto the earliest server
  assign sum_full = SUM_W'(res_r.best_t) + SUM_W'(dur_r);
  assign sum_sat  = (sum_full > SUM_W'(TIME_MAX)) ? TIME_MAX : sum_full[TIME_BITS-1:0];

  // Next server: the updated pick against the runner-up, lower number on a tie
  assign take_sec = res_r.sec_vld &&
                    ((res_r.sec_t < sum_r) ||
                     ((res_r.sec_t == sum_r) && (res_r.sec_idx < res_r.best_idx)));

  always_ff @(posedge clk) begin
    if (accept) begin
      dur_r <= in_job_duration;
    end
    if ((state_r == ST_SWEEP) && chain[MAX_SERVERS].vld) begin
      res_r <= chain[MAX_SERVERS];
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_sat;
    end
    if (do_write) begin
      out_assigned_r <= SRV_W'(res_r.best_idx) + SRV_W'(1);
      if (take_sec) begin
        out_next_r <= SRV_W'(res_r.sec_idx) + SRV_W'(1);
        out_time_r <= OUT_TIME_W'(res_r.sec_t);
      end else begin
        out_next_r <= SRV_W'(res_r.best_idx) + SRV_W'(1);
        out_time_r <= OUT_TIME_W'(sum_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= do_write;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_assigned_server = out_assigned_r;
  assign out_next_server     = out_next_r;
  assign out_next_free_time  = out_time_r;

endmodule
